@@ rtl/pti_pkg.sv @@
// Shared constants, types and sine table for the particle turbulence integrator.
`timescale 1ns / 1ps
package pti_pkg;

  localparam int TABLE_SIZE = 2048;
  localparam int TABLE_BITS = $clog2(TABLE_SIZE);
  localparam int COMP_W = 20;
  localparam int AGE_W = 24;
  localparam int ROM_W = 16;
  localparam int CFG_IDX_W = 3;

  localparam logic [63:0] TWO_PI_Q30 = 64'd6746518852;
  localparam logic [63:0] PI_Q30 = 64'd3373259426;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] ROM_DEN = (TABLE_SIZE > 1) ? 64'(TABLE_SIZE - 1) : 64'd1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_AGE_STEP = 3'd0,
    REG_GRAVITY  = 3'd1,
    REG_EXT_VX   = 3'd2,
    REG_EXT_VY   = 3'd3,
    REG_EXT_VZ   = 3'd4,
    REG_LIFESPAN = 3'd5
  } cfg_reg_t;

  typedef logic signed [ROM_W-1:0] sin_rom_t [TABLE_SIZE];

  // Fold into the first quadrant and run the Taylor series to the x^15 term.
  function automatic sin_rom_t build_sin_rom();
    sin_rom_t   rom;
    logic [63:0] theta;
    logic [63:0] x2;
    logic [63:0] mag;
    logic [63:0] sum;
    logic        neg;
    for (int i = 0; i < TABLE_SIZE; i++) begin
      theta = (TWO_PI_Q30 * 64'(i)) / ROM_DEN;
      neg = 1'b0;
      if (theta > PI_Q30) begin
        theta = theta - PI_Q30;
        neg = 1'b1;
      end
      if (theta > HALF_PI_Q30) theta = (theta > PI_Q30) ? 64'd0 : PI_Q30 - theta;
      x2 = (theta * theta) >> 30;
      mag = theta;
      sum = theta;
      for (int k = 1; k <= 7; k++) begin
        mag = ((mag * x2) >> 30) / 64'((2 * k) * (2 * k + 1));
        if (k % 2 == 1) sum = (sum >= mag) ? sum - mag : 64'd0;
        else sum = sum + mag;
      end
      sum = (sum + 64'd32768) >> 16;
      rom[i] = neg ? -ROM_W'(sum) : ROM_W'(sum);
    end
    return rom;
  endfunction

  localparam sin_rom_t SIN_ROM = build_sin_rom();

  function automatic logic signed [COMP_W-1:0] sat20(input logic signed [39:0] v);
    if (v > 40'sd524287) return 20'sd524287;
    if (v < -40'sd524288) return -20'sd524288;
    return v[COMP_W-1:0];
  endfunction

endpackage

@@ rtl/particle_turbulence_integrator.sv @@
// Top level: seven-stage particle update pipeline with sine turbulence.
//
//  port group | dir | contents
//  in_*       | in  | particle record word
//  out_*      | out | updated record word, expired flag in tuser
//  cfg_*      | in  | register writes
//
// One word enters per cycle while the output is not stalled; each word passes the multiplier
// chain (index product, sine lookup, amplitude scale, frame products, sum).
// Reset (rst_n low, synchronous) empties the pipeline and loads register defaults.
// A stalled output freezes every stage; in_tready is low only while the
// output register is full and not taken.
`timescale 1ns / 1ps
module particle_turbulence_integrator (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // position[59:0] tangent[119:60] binormal[179:120] normal[239:180]
  // phase_triplet[287:240] frequency_triplet[335:288] amplitude_triplet[395:336]
  // base_speed[415:396] acceleration[435:416] age[459:436], zero fill above
  input  logic [463:0]                        in_tdata,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // new_position[59:0] velocity[119:60] new_age[143:120]
  output logic [143:0]                        out_tdata,
  // expired[0]
  output logic                                out_tuser,
  input  logic                                cfg_wr_en,
  input  logic [pti_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [23:0]                         cfg_wdata
);

  localparam int TB = pti_pkg::TABLE_BITS;

  logic        en;
  logic [6:0]  vld_r;

  logic [23:0]        age_step_r, lifespan_r;
  logic signed [19:0] gravity_r;
  logic signed [19:0] wind_r [3];

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      age_step_r <= 24'd1638;
      gravity_r  <= 20'sd0;
      wind_r[0]  <= 20'sd1311;
      wind_r[1]  <= 20'sd0;
      wind_r[2]  <= 20'sd0;
      lifespan_r <= 24'd65536;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        pti_pkg::REG_AGE_STEP: age_step_r <= cfg_wdata;
        pti_pkg::REG_GRAVITY:  gravity_r  <= cfg_wdata[19:0];
        pti_pkg::REG_EXT_VX:   wind_r[0]  <= cfg_wdata[19:0];
        pti_pkg::REG_EXT_VY:   wind_r[1]  <= cfg_wdata[19:0];
        pti_pkg::REG_EXT_VZ:   wind_r[2]  <= cfg_wdata[19:0];
        pti_pkg::REG_LIFESPAN: lifespan_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign en = !vld_r[6] || out_tready;
  assign in_tready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else if (en) vld_r <= {vld_r[5:0], in_tvalid};
  end

  // input field views
  logic [59:0] i_pos, i_tan, i_bin, i_nrm, i_amp;
  logic [47:0] i_ph, i_fr;
  logic signed [19:0] i_base, i_acc;
  logic [23:0] i_age;
  assign i_pos  = in_tdata[59:0];
  assign i_tan  = in_tdata[119:60];
  assign i_bin  = in_tdata[179:120];
  assign i_nrm  = in_tdata[239:180];
  assign i_ph   = in_tdata[287:240];
  assign i_fr   = in_tdata[335:288];
  assign i_amp  = in_tdata[395:336];
  assign i_base = in_tdata[415:396];
  assign i_acc  = in_tdata[435:416];
  assign i_age  = in_tdata[459:436];

  // stage 1: index products, speed and gravity products, expiry compare
  logic [27:0]        s1_idx_r [3];
  logic signed [44:0] s1_pa_r, s1_pg_r;
  logic signed [19:0] s1_base_r;
  logic [59:0]        s1_pos_r, s1_tan_r, s1_bin_r, s1_nrm_r, s1_amp_r;
  logic [23:0]        s1_age_r;
  logic               s1_exp_r;
  logic [39:0]        af [3];

  always_comb begin
    for (int k = 0; k < 3; k++) af[k] = i_age * i_fr[16*k +: 16];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) s1_idx_r[k] <= af[k][27:0] + {i_ph[16*k +: 16], 12'd0};
      s1_pa_r   <= $signed({1'b0, i_age}) * i_acc;
      s1_pg_r   <= $signed({1'b0, i_age}) * gravity_r;
      s1_base_r <= i_base;
      s1_pos_r  <= i_pos;
      s1_tan_r  <= i_tan;
      s1_bin_r  <= i_bin;
      s1_nrm_r  <= i_nrm;
      s1_amp_r  <= i_amp;
      s1_age_r  <= i_age;
      s1_exp_r  <= i_age > lifespan_r;
    end
  end

  // stage 2: sine lookup, rounded speed and gravity terms
  logic signed [15:0] rom_q [3];
  for (genvar g = 0; g < 3; g++) begin : g_rom
    pti_sin_rom u_rom (
      .clk    (clk),
      .en     (en),
      .addr   (s1_idx_r[g][27 -: TB]),
      .data_r (rom_q[g])
    );
  end

  logic signed [45:0] pa_rnd, pg_rnd;
  assign pa_rnd = 46'(s1_pa_r) + 46'sd32768;
  assign pg_rnd = 46'(s1_pg_r) + 46'sd32768;

  logic signed [29:0] s2_sp_r, s2_gr_r;
  logic [59:0]        s2_pos_r, s2_tan_r, s2_bin_r, s2_nrm_r, s2_amp_r;
  logic [23:0]        s2_age_r;
  logic               s2_exp_r;

  always_ff @(posedge clk) begin
    if (en) begin
      s2_sp_r  <= pa_rnd[45:16] + 30'(s1_base_r);
      s2_gr_r  <= pg_rnd[45:16];
      s2_pos_r <= s1_pos_r;
      s2_tan_r <= s1_tan_r;
      s2_bin_r <= s1_bin_r;
      s2_nrm_r <= s1_nrm_r;
      s2_amp_r <= s1_amp_r;
      s2_age_r <= s1_age_r;
      s2_exp_r <= s1_exp_r;
    end
  end

  // stage 3: amplitude scale
  logic signed [35:0] s3_tp_r [3];
  logic signed [29:0] s3_sp_r, s3_gr_r;
  logic [59:0]        s3_pos_r, s3_tan_r, s3_bin_r, s3_nrm_r;
  logic [23:0]        s3_age_r;
  logic               s3_exp_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++)
        s3_tp_r[k] <= $signed(s2_amp_r[20*k +: 20]) * rom_q[k];
      s3_sp_r  <= s2_sp_r;
      s3_gr_r  <= s2_gr_r;
      s3_pos_r <= s2_pos_r;
      s3_tan_r <= s2_tan_r;
      s3_bin_r <= s2_bin_r;
      s3_nrm_r <= s2_nrm_r;
      s3_age_r <= s2_age_r;
      s3_exp_r <= s2_exp_r;
    end
  end

  // stage 4: round turbulence; full negative amplitude times a negative peak needs 21 bits
  logic signed [36:0] tp_rnd [3];
  always_comb begin
    for (int k = 0; k < 3; k++) tp_rnd[k] = 37'(s3_tp_r[k]) + 37'sd8192;
  end

  logic signed [20:0] s4_tb_r [3];
  logic signed [29:0] s4_sp_r, s4_gr_r;
  logic [59:0]        s4_pos_r, s4_tan_r, s4_bin_r, s4_nrm_r;
  logic [23:0]        s4_age_r;
  logic               s4_exp_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) s4_tb_r[k] <= tp_rnd[k][34:14];
      s4_sp_r  <= s3_sp_r;
      s4_gr_r  <= s3_gr_r;
      s4_pos_r <= s3_pos_r;
      s4_tan_r <= s3_tan_r;
      s4_bin_r <= s3_bin_r;
      s4_nrm_r <= s3_nrm_r;
      s4_age_r <= s3_age_r;
      s4_exp_r <= s3_exp_r;
    end
  end

  // stage 5: frame products
  logic signed [49:0] s5_pn_r [3];
  logic signed [40:0] s5_pt_r [3], s5_pb_r [3], s5_pq_r [3];
  logic signed [29:0] s5_gr_r;
  logic [59:0]        s5_pos_r;
  logic [23:0]        s5_age_r;
  logic               s5_exp_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        s5_pn_r[k] <= $signed(s4_nrm_r[20*k +: 20]) * s4_sp_r;
        s5_pt_r[k] <= $signed(s4_tan_r[20*k +: 20]) * s4_tb_r[0];
        s5_pb_r[k] <= $signed(s4_bin_r[20*k +: 20]) * s4_tb_r[1];
        s5_pq_r[k] <= $signed(s4_nrm_r[20*k +: 20]) * s4_tb_r[2];
      end
      s5_gr_r  <= s4_gr_r;
      s5_pos_r <= s4_pos_r;
      s5_age_r <= s4_age_r;
      s5_exp_r <= s4_exp_r;
    end
  end

  // stage 6: frame sum, wind, gravity, saturate
  logic signed [51:0] acc_rnd [3];
  logic signed [39:0] vsum [3];
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      acc_rnd[k] = 52'(s5_pn_r[k]) + 52'(s5_pt_r[k]) + 52'(s5_pb_r[k]) + 52'(s5_pq_r[k])
                 + 52'sd8192;
      vsum[k] = 40'($signed(acc_rnd[k][51:14])) + 40'(wind_r[k]);
    end
    vsum[1] = vsum[1] - 40'(s5_gr_r);
  end

  logic signed [19:0] s6_v_r [3];
  logic [59:0]        s6_pos_r;
  logic [23:0]        s6_age_r;
  logic               s6_exp_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) s6_v_r[k] <= pti_pkg::sat20(vsum[k]);
      s6_pos_r <= s5_pos_r;
      s6_age_r <= s5_age_r;
      s6_exp_r <= s5_exp_r;
    end
  end

  // stage 7: position, age, output word
  logic [59:0] npos, nvel;
  logic [24:0] age_sum;
  logic [23:0] nage;
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      npos[20*k +: 20] = pti_pkg::sat20(40'($signed(s6_pos_r[20*k +: 20])) + 40'(s6_v_r[k]));
      nvel[20*k +: 20] = s6_v_r[k];
    end
    age_sum = {1'b0, s6_age_r} + {1'b0, age_step_r};
    nage = age_sum[24] ? 24'hFFFFFF : age_sum[23:0];
  end

  logic [143:0] out_data_r;
  logic         out_exp_r;
  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r <= s6_exp_r ? {s6_age_r, 60'd0, s6_pos_r} : {nage, nvel, npos};
      out_exp_r  <= s6_exp_r;
    end
  end

  assign out_tvalid = vld_r[6];
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_exp_r;

  a_enter: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> vld_r[0])
    else $error("accepted word missing from first stage");
  a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(vld_r))
    else $error("pipeline moved during stall");
  a_exp_vel: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata[119:60] == 60'd0)
    else $error("expired word carries velocity");
  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[5] && en |=> out_tvalid)
    else $error("word lost before output");

endmodule

@@ rtl/pti_sin_rom.sv @@
// Sine lookup with a registered read port.
`timescale 1ns / 1ps
module pti_sin_rom (
  input  logic                                 clk,
  input  logic                                 en,
  input  logic [pti_pkg::TABLE_BITS-1:0]       addr,
  output logic signed [pti_pkg::ROM_W-1:0]     data_r
);

  always_ff @(posedge clk) begin
    if (en) data_r <= pti_pkg::SIN_ROM[addr];
  end

endmodule

@@ bench/tb_particle_turbulence_integrator.sv @@
// Self-checking testbench for the particle turbulence integrator pipeline.
`timescale 1ns / 1ps
module tb_particle_turbulence_integrator;

  typedef struct {
    logic [59:0] pos;
    logic [59:0] tan;
    logic [59:0] bin;
    logic [59:0] nrm;
    logic [47:0] phase;
    logic [47:0] freq;
    logic [59:0] amp;
    logic [19:0] speed;
    logic [19:0] accel;
    logic [23:0] age;
  } particle_t;

  typedef struct {
    logic [59:0] new_pos;
    logic [59:0] vel;
    logic [23:0] new_age;
    logic        expired;
  } update_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [463:0] in_tdata = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [143:0] out_tdata;
  logic         out_tuser;
  logic         cfg_wr_en = 1'b0;
  logic [pti_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [23:0]  cfg_wdata = '0;

  particle_turbulence_integrator i_dut (.*);

  // own copy of the register file
  logic [23:0] m_age_step = 24'd1638;
  logic [19:0] m_gravity = 20'd0;
  logic [19:0] m_wind [3] = '{20'd1311, 20'd0, 20'd0};
  logic [23:0] m_expiry_age = 24'd65536;

  longint    sine_tab [pti_pkg::TABLE_SIZE];
  particle_t particles_to_send [$];
  particle_t particle_on_bus;
  update_t   updates_due [$];
  int        send_idle_pct = 0;
  int        recv_stall_pct = 0;
  int        errors = 0;
  logic      hold_req = 1'b0;
  int        hold_left = 0;

  initial forever #6 clk = ~clk;

  initial begin
    #20ms;
    $display("status: fail");
    $finish;
  end

  // Fold into one quadrant, Taylor series to x^15, Q30 reduced to Q14.
  function automatic void fill_sine();
    longint unsigned th, x2, mag, acc;
    logic neg;
    for (int i = 0; i < pti_pkg::TABLE_SIZE; i++) begin
      th = (64'd6746518852 * longint'(i)) / longint'(pti_pkg::TABLE_SIZE - 1);
      neg = 1'b0;
      if (th > 64'd3373259426) begin
        th -= 64'd3373259426;
        neg = 1'b1;
      end
      if (th > 64'd1686629713) th = (th > 64'd3373259426) ? 0 : 64'd3373259426 - th;
      x2 = (th * th) >> 30;
      mag = th;
      acc = th;
      for (int k = 1; k <= 7; k++) begin
        mag = ((mag * x2) >> 30) / longint'((2 * k) * (2 * k + 1));
        if (k % 2 == 1) acc = (acc >= mag) ? acc - mag : 0;
        else acc += mag;
      end
      acc = (acc + 64'd32768) >> 16;
      sine_tab[i] = neg ? -longint'(acc) : longint'(acc);
    end
  endfunction

  function automatic longint sx(logic [19:0] v);
    return longint'($signed(v));
  endfunction

  function automatic longint round_sh(longint v, int sh);
    return (v + (longint'(1) << (sh - 1))) >>> sh;
  endfunction

  function automatic longint clamp20(longint v);
    if (v > 524287) return 524287;
    if (v < -524288) return -524288;
    return v;
  endfunction

  function automatic update_t advance_particle(particle_t p);
    update_t r;
    longint turb [3];
    longint unsigned s, na;
    longint spd, grav, acc, v, nk;
    if (p.age > m_expiry_age) begin
      r.new_pos = p.pos;
      r.vel = '0;
      r.new_age = p.age;
      r.expired = 1'b1;
      return r;
    end
    for (int k = 0; k < 3; k++) begin
      s = longint'(p.age) * longint'(p.freq[16*k +: 16]) + (longint'(p.phase[16*k +: 16]) << 12);
      turb[k] = round_sh(sx(p.amp[20*k +: 20]) * sine_tab[(s >> 17) % pti_pkg::TABLE_SIZE], 14);
    end
    spd = sx(p.speed) + round_sh(longint'(p.age) * sx(p.accel), 16);
    grav = round_sh(longint'(p.age) * sx(m_gravity), 16);
    for (int k = 0; k < 3; k++) begin
      nk = sx(p.nrm[20*k +: 20]);
      acc = nk * spd + sx(p.tan[20*k +: 20]) * turb[0] + sx(p.bin[20*k +: 20]) * turb[1]
            + nk * turb[2];
      v = round_sh(acc, 14) + sx(m_wind[k]);
      if (k == 1) v -= grav;
      v = clamp20(v);
      r.vel[20*k +: 20] = v[19:0];
      r.new_pos[20*k +: 20] = 20'(clamp20(sx(p.pos[20*k +: 20]) + v));
    end
    na = longint'(p.age) + longint'(m_age_step);
    r.new_age = (na > 64'd16777215) ? 24'hFFFFFF : na[23:0];
    r.expired = 1'b0;
    return r;
  endfunction

  // Driver: hold the word until taken, then predict and advance.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) updates_due.push_back(advance_particle(particle_on_bus));
      if (!in_tvalid || in_tready) begin
        if (particles_to_send.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          particle_on_bus = particles_to_send.pop_front();
          in_tvalid <= 1'b1;
          in_tdata <= {4'd0, particle_on_bus.age, particle_on_bus.accel, particle_on_bus.speed,
                       particle_on_bus.amp, particle_on_bus.freq, particle_on_bus.phase,
                       particle_on_bus.nrm, particle_on_bus.bin, particle_on_bus.tan,
                       particle_on_bus.pos};
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off, counted here.
  always @(posedge clk) begin
    if (hold_req) begin
      hold_left <= 400;
      hold_req <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Monitor: compare each taken word with the oldest prediction.
  always @(posedge clk) begin
    update_t e;
    if (rst_n) begin
      out_tready <= (hold_left == 0 && !hold_req) && ($urandom_range(99) >= recv_stall_pct);
      if (out_tvalid && out_tready) begin
        if (updates_due.size() == 0) begin
          $error("unexpected word: %h user %b", out_tdata, out_tuser);
          errors++;
        end else begin
          e = updates_due.pop_front();
          if (out_tdata[59:0] !== e.new_pos) begin
            $error("new_position expected %h got %h", e.new_pos, out_tdata[59:0]);
            errors++;
          end
          if (out_tdata[119:60] !== e.vel) begin
            $error("velocity expected %h got %h", e.vel, out_tdata[119:60]);
            errors++;
          end
          if (out_tdata[143:120] !== e.new_age) begin
            $error("new_age expected %h got %h", e.new_age, out_tdata[143:120]);
            errors++;
          end
          if (out_tuser !== e.expired) begin
            $error("expired expected %b got %b", e.expired, out_tuser);
            errors++;
          end
        end
      end
    end
  end

  task automatic write_reg(pti_pkg::cfg_reg_t r, logic [23:0] v);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= r;
    cfg_wdata <= v;
    case (r)
      pti_pkg::REG_AGE_STEP: m_age_step = v;
      pti_pkg::REG_GRAVITY:  m_gravity = v[19:0];
      pti_pkg::REG_EXT_VX:   m_wind[0] = v[19:0];
      pti_pkg::REG_EXT_VY:   m_wind[1] = v[19:0];
      pti_pkg::REG_EXT_VZ:   m_wind[2] = v[19:0];
      pti_pkg::REG_LIFESPAN: m_expiry_age = v;
      default: ;
    endcase
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic drain();
    while (particles_to_send.size() > 0 || in_tvalid || updates_due.size() > 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic write_all(logic [23:0] st, logic [19:0] g, logic [19:0] wx, logic [19:0] wy,
                           logic [19:0] wz, logic [23:0] life);
    write_reg(pti_pkg::REG_AGE_STEP, st);
    write_reg(pti_pkg::REG_GRAVITY, {4'd0, g});
    write_reg(pti_pkg::REG_EXT_VX, {4'd0, wx});
    write_reg(pti_pkg::REG_EXT_VY, {4'd0, wy});
    write_reg(pti_pkg::REG_EXT_VZ, {4'd0, wz});
    write_reg(pti_pkg::REG_LIFESPAN, life);
  endtask

  function automatic logic [59:0] rvec();
    return {20'($urandom_range(20'hFFFFF)), 20'($urandom_range(20'hFFFFF)),
            20'($urandom_range(20'hFFFFF))};
  endfunction

  // Mostly unit-scale frames and live ages; the rest full-range noise.
  function automatic particle_t rand_particle();
    particle_t p;
    logic [19:0] one;
    p.pos = rvec();
    p.amp = rvec();
    p.phase = 48'({$urandom(), $urandom()});
    p.freq = 48'({$urandom(), $urandom()});
    p.speed = 20'($urandom());
    p.accel = 20'($urandom());
    if ($urandom_range(3) != 0) begin
      one = $urandom_range(1) ? 20'd16384 : -20'sd16384;
      p.tan = {20'($urandom_range(33000) - 16500), 20'd0, one};
      p.bin = {20'd0, one, 20'($urandom_range(33000) - 16500)};
      p.nrm = {one, 20'($urandom_range(33000) - 16500), 20'd0};
      p.age = 24'($urandom_range(m_expiry_age));
    end else begin
      p.tan = rvec();
      p.bin = rvec();
      p.nrm = rvec();
      p.age = 24'($urandom());
    end
    return p;
  endfunction

  task automatic add_random(int n);
    repeat (n) particles_to_send.push_back(rand_particle());
  endtask

  initial begin
    particle_t d;
    fill_sine();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // directed: zeros, all ones, frame extremes, lifespan edge, saturation, phase sweep
    d = '{default: '0};
    particles_to_send.push_back(d);
    d.age = 24'd65536;
    particles_to_send.push_back(d);
    d.age = 24'd65537;
    particles_to_send.push_back(d);
    d = '{pos: '1, tan: '1, bin: '1, nrm: '1, phase: '1, freq: '1, amp: '1,
          speed: '1, accel: '1, age: 24'd100};
    particles_to_send.push_back(d);
    d.age = '1;
    particles_to_send.push_back(d);
    d = '{pos: {3{20'h7FFFF}}, tan: {3{20'h7FFFF}}, bin: {3{20'h7FFFF}},
          nrm: {3{20'h7FFFF}}, phase: '1, freq: '1, amp: {3{20'h7FFFF}},
          speed: 20'h7FFFF, accel: 20'h7FFFF, age: 24'd65536};
    particles_to_send.push_back(d);
    d = '{pos: {3{20'h80000}}, tan: {3{20'h80000}}, bin: {3{20'h80000}},
          nrm: {3{20'h80000}}, phase: '0, freq: '0, amp: {3{20'h80000}},
          speed: 20'h80000, accel: 20'h80000, age: 24'd0};
    particles_to_send.push_back(d);
    d.amp = {3{20'h7FFFF}};
    d.phase = {3{16'h4000}};
    particles_to_send.push_back(d);
    for (int i = 0; i < 8; i++) begin
      d = '{pos: 60'd0, tan: {40'd0, 20'd16384}, bin: {20'd0, 20'd16384, 20'd0},
            nrm: {20'd16384, 40'd0}, phase: {3{16'(i * 8192)}}, freq: {3{16'd4096}},
            amp: {3{20'd16384}}, speed: 20'd16384, accel: 20'd8192, age: 24'(i * 8000)};
      particles_to_send.push_back(d);
    end
    drain();

    write_all(24'($urandom()), 20'($urandom()), 20'($urandom()), 20'($urandom()),
              20'($urandom()), 24'hFFFFFF);
    send_idle_pct = 74;
    add_random(450);
    drain();

    write_all(24'hFFFFFF, 20'h80000, 20'h7FFFF, 20'h7FFFF, 20'h7FFFF, 24'hFFFFFF);
    send_idle_pct = 0;
    recv_stall_pct = 74;
    add_random(450);
    repeat (30) @(posedge clk);
    hold_req = 1'b1;
    drain();

    write_all(24'd0, 20'h7FFFF, 20'h80000, 20'h80000, 20'h80000, 24'd0);
    send_idle_pct = 11;
    recv_stall_pct = 11;
    add_random(60);
    drain();
    write_reg(pti_pkg::REG_LIFESPAN, 24'($urandom()));
    add_random(400);
    drain();

    write_all(24'($urandom()), 20'($urandom()), 20'($urandom()), 20'($urandom()),
              20'($urandom()), 24'hFFFFFF);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    add_random(450);
    drain();

    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/pti_pkg.sv
rtl/pti_sin_rom.sv
rtl/particle_turbulence_integrator.sv
bench/tb_particle_turbulence_integrator.sv
